// ----- rtl/axis_rotation_with_offset_core_assert.svh -----
// Assertion macros for the axis rotation core checker.
`ifndef AXIS_ROTATION_WITH_OFFSET_CORE_ASSERT_SVH
`define AXIS_ROTATION_WITH_OFFSET_CORE_ASSERT_SVH
// implication checked every clock, quiet in reset
`define AROT_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m failed");
`endif

// ----- rtl/arot_pkg.sv -----
// Package for the axis rotation core: payload types and constants.
package arot_pkg;
   localparam int unsigned TrigFrac = 30;
   localparam int unsigned AngleW = 26;
   localparam logic signed [31:0] TrigOne = 32'sh4000_0000;
   localparam logic signed [31:0] CordicGain = 32'sh26DD_3B6A;
   localparam logic [24:0] Deg2Rad = 25'd18740330;
   localparam logic signed [31:0] Full = 32'sd23592960;
   localparam logic signed [31:0] Half = 32'sd11796480;
   localparam logic signed [31:0] Quarter = 32'sd5898240;

   localparam logic [2:0] RegAxis = 3'd0;
   localparam logic [2:0] RegAngle = 3'd1;
   localparam logic [2:0] RegCx = 3'd2;
   localparam logic [2:0] RegCy = 3'd3;
   localparam logic [2:0] RegCz = 3'd4;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   typedef struct packed {
      logic signed [31:0] rel_x;
      logic signed [31:0] rel_y;
      logic signed [31:0] rel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic signed [31:0] abs_x;
      logic signed [31:0] abs_y;
      logic signed [31:0] abs_z;
   } rsp_type;

   function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0: r = 32'sd843314857;
         5'd1: r = 32'sd497837829;
         5'd2: r = 32'sd263043837;
         5'd3: r = 32'sd133525159;
         5'd4: r = 32'sd67021687;
         5'd5: r = 32'sd33543516;
         5'd6: r = 32'sd16775851;
         5'd7: r = 32'sd8388437;
         5'd8: r = 32'sd4194283;
         5'd9: r = 32'sd2097149;
         default: r = 32'sd1 <<< (5'd30 - i);
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// ----- rtl/arot_trig.sv -----
// Sequential CORDIC unit: angle in degrees to sine and cosine in Q2.30.
module arot_trig #(
   parameter int unsigned CORDIC_ITERATIONS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic signed [25:0]  angle,
   output logic signed [31:0]  sine,
   output logic signed [31:0]  cosine,
   output logic                busy
);
   import arot_pkg::*;

   localparam int unsigned Iters = (CORDIC_ITERATIONS < 31) ? CORDIC_ITERATIONS : 31;

   typedef enum logic [2:0] {S_IDLE, S_MOD, S_FOLD, S_RAD, S_ITER, S_DONE} state_type;

   state_type state_ff;
   logic signed [31:0] r_ff;
   logic flip_ff, neg_ff;
   logic signed [34:0] x_ff, y_ff, z_ff;
   logic [4:0] i_ff;
   logic signed [31:0] sine_ff, cosine_ff;
   logic [56:0] prod;
   logic signed [34:0] xs, ys, at, cx, cy;

   assign prod = 57'(r_ff[31:0]) * 57'(Deg2Rad);
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = 35'(atan_q30(i_ff));
   assign cx = (x_ff > 35'(TrigOne)) ? 35'(TrigOne) : x_ff;
   assign cy = (y_ff > 35'(TrigOne)) ? 35'(TrigOne) :
               (y_ff < -35'(TrigOne)) ? -35'(TrigOne) : y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sine_ff   <= '0;
         cosine_ff <= TrigOne;
      end else if (load) begin
         // a new angle always restarts the run
         r_ff <= 32'(angle);
         state_ff <= S_MOD;
      end else begin
         case (state_ff)
            S_IDLE: state_ff <= S_IDLE;
            S_MOD: begin
               // |angle| < 512 degrees (26-bit input), so at most one step down, or up to two steps up
               if (r_ff >= Full) r_ff <= r_ff - Full;
               else if (r_ff <= -Full) r_ff <= r_ff + Full;
               else if (r_ff < 0) r_ff <= r_ff + Full;
               else state_ff <= S_FOLD;
            end
            S_FOLD: begin
               logic signed [31:0] t;
               logic f;
               t = (r_ff > Half) ? r_ff - Full : r_ff;
               f = 1'b0;
               if (t > Quarter) begin t = Half - t; f = 1'b1; end
               else if (t < -Quarter) begin t = -Half - t; f = 1'b1; end
               flip_ff <= f;
               neg_ff <= t < 0;
               r_ff <= (t < 0) ? -t : t;
               state_ff <= S_RAD;
            end
            S_RAD: begin
               z_ff <= 35'((prod + 57'd32768) >> 16);
               x_ff <= 35'(CordicGain);
               y_ff <= '0;
               i_ff <= '0;
               state_ff <= (Iters == 0) ? S_DONE : S_ITER;
            end
            S_ITER: begin
               if (z_ff >= 0) begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + at;
               end
               i_ff <= i_ff + 5'd1;
               if (i_ff == 5'(Iters - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               cosine_ff <= flip_ff ? -cx[31:0] : cx[31:0];
               sine_ff <= neg_ff ? -cy[31:0] : cy[31:0];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sine = sine_ff;
   assign cosine = cosine_ff;
   assign busy = state_ff != S_IDLE;
endmodule

// ----- rtl/axis_rotation_with_offset_core.sv -----
// Axis rotation core: point rotation about X, Y or Z plus center offset.
// A beat taken on start passes the operand, product, sum and offset stages to rsp_valid;
// one beat accepted every cycle while busy is low. Angle write starts a CORDIC run (zero
// to two wrap steps); busy high meanwhile, and a new angle write restarts the run.
// Reset (synchronous, high) clears valids, the CSRs, sine to 0 and cosine to one.
// Results cannot be stalled; one beat per cycle on rsp_valid.
module axis_rotation_with_offset_core #(
   parameter int unsigned COORD_FRAC_BITS = 16,
   parameter int unsigned CORDIC_ITERATIONS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  arot_pkg::req_type req_data,
   output logic              rsp_valid,
   output arot_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import arot_pkg::*;

   // CSRs
   logic [1:0] axis_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic trig_busy;
   logic signed [31:0] sine, cosine;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= AxisX;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            RegAxis: axis_ff <= csr_wdata[1:0];
            RegCx: cx_ff <= csr_wdata;
            RegCy: cy_ff <= csr_wdata;
            RegCz: cz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   arot_trig #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_trig (
      .clock(clock), .reset(reset),
      .load(csr_we && csr_index == RegAngle),
      .angle(csr_wdata[AngleW-1:0]),
      .sine(sine), .cosine(cosine), .busy(trig_busy)
   );

   // frac bits of the coordinates do not change the rescale shift
   logic unused_frac;
   assign unused_frac = (COORD_FRAC_BITS == 0);
   assign busy = trig_busy | unused_frac;

   logic take;
   assign take = start && !busy;

   // Stage 1: pick operand pairs per axis. out_a = a*c + b*d
   logic v1_ff;
   logic signed [31:0] pa_a_ff, pa_c_ff, pa_b_ff, pa_d_ff;
   logic signed [31:0] pb_a_ff, pb_c_ff, pb_b_ff, pb_d_ff;
   logic signed [31:0] keep_ff;
   logic [1:0] ax1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= take;
      ax1_ff <= axis_ff;
      case (axis_ff)
         AxisX: begin
            pa_a_ff <= req_data.rel_y; pa_c_ff <= cosine;
            pa_b_ff <= req_data.rel_z; pa_d_ff <= -sine;
            pb_a_ff <= req_data.rel_y; pb_c_ff <= sine;
            pb_b_ff <= req_data.rel_z; pb_d_ff <= cosine;
            keep_ff <= req_data.rel_x;
         end
         AxisY: begin
            pa_a_ff <= req_data.rel_x; pa_c_ff <= cosine;
            pa_b_ff <= req_data.rel_z; pa_d_ff <= sine;
            pb_a_ff <= req_data.rel_z; pb_c_ff <= cosine;
            pb_b_ff <= req_data.rel_x; pb_d_ff <= -sine;
            keep_ff <= req_data.rel_y;
         end
         AxisZ: begin
            pa_a_ff <= req_data.rel_x; pa_c_ff <= cosine;
            pa_b_ff <= req_data.rel_y; pa_d_ff <= -sine;
            pb_a_ff <= req_data.rel_x; pb_c_ff <= sine;
            pb_b_ff <= req_data.rel_y; pb_d_ff <= cosine;
            keep_ff <= req_data.rel_z;
         end
         default: begin
            // no rotation: pass through with unit factors (c=1, d=0)
            pa_a_ff <= req_data.rel_x; pa_c_ff <= TrigOne;
            pa_b_ff <= req_data.rel_y; pa_d_ff <= '0;
            pb_a_ff <= req_data.rel_y; pb_c_ff <= TrigOne;
            pb_b_ff <= req_data.rel_x; pb_d_ff <= '0;
            keep_ff <= req_data.rel_z;
         end
      endcase
   end

   // Stage 2: four 32x32 products
   logic v2_ff;
   logic [1:0] ax2_ff;
   logic signed [63:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [31:0] keep2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      ax2_ff <= ax1_ff;
      keep2_ff <= keep_ff;
      m0_ff <= pa_a_ff * pa_c_ff;
      m1_ff <= pa_b_ff * pa_d_ff;
      m2_ff <= pb_a_ff * pb_c_ff;
      m3_ff <= pb_b_ff * pb_d_ff;
   end

   // Stage 3: sum, round half up, saturate
   logic signed [64:0] sa, sb;
   logic signed [34:0] ha, hb;
   logic signed [34:0] qa, qb;
   assign sa = 65'(m0_ff) + 65'(m1_ff) + 65'sd536870912;
   assign sb = 65'(m2_ff) + 65'(m3_ff) + 65'sd536870912;
   // signed view of the rescaled sums
   assign ha = sa[64:30];
   assign hb = sb[64:30];
   assign qa = (ha > 35'sh0_7FFF_FFFF) ? 35'sh0_7FFF_FFFF :
               (ha < -35'sh0_8000_0000) ? -35'sh0_8000_0000 : ha;
   assign qb = (hb > 35'sh0_7FFF_FFFF) ? 35'sh0_7FFF_FFFF :
               (hb < -35'sh0_8000_0000) ? -35'sh0_8000_0000 : hb;

   logic v3_ff;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      case (ax2_ff)
         AxisX: begin
            rx_ff <= keep2_ff; ry_ff <= qa[31:0]; rz_ff <= qb[31:0];
         end
         AxisY: begin
            rx_ff <= qa[31:0]; ry_ff <= keep2_ff; rz_ff <= qb[31:0];
         end
         AxisZ: begin
            rx_ff <= qa[31:0]; ry_ff <= qb[31:0]; rz_ff <= keep2_ff;
         end
         default: begin
            rx_ff <= qa[31:0]; ry_ff <= qb[31:0]; rz_ff <= keep2_ff;
         end
      endcase
   end

   // Stage 4: center offset with saturation; output register
   logic v4_ff;
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      out_ff.rot_x <= rx_ff;
      out_ff.rot_y <= ry_ff;
      out_ff.rot_z <= rz_ff;
      out_ff.abs_x <= sat32(34'(rx_ff) + 34'(cx_ff));
      out_ff.abs_y <= sat32(34'(ry_ff) + 34'(cy_ff));
      out_ff.abs_z <= sat32(34'(rz_ff) + 34'(cz_ff));
   end

   assign rsp_valid = v4_ff;
   assign rsp_data = out_ff;
endmodule

// ----- rtl/arot_checker.sv -----
// Port-level checker for the axis rotation core, with its bind.
`include "axis_rotation_with_offset_core_assert.svh"
module arot_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_we,
   input logic [2:0] csr_index
);
   import arot_pkg::*;
   logic acc;
   assign acc = start && !busy;
   `AROT_ASSERT_IMP(a_latency, clock, reset, acc, ##4 rsp_valid)
   `AROT_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(acc, 4))
   `AROT_ASSERT_IMP(a_angle_busy, clock, reset, csr_we && csr_index == RegAngle, ##1 busy)
endmodule

bind axis_rotation_with_offset_core arot_checker u_arot_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .csr_we(csr_we), .csr_index(csr_index)
);
